// ===== hw/rtl/sltf_pkg.sv =====
// ----------------------------------------------------------------------------
// sltf_pkg: types and codes for the sorted lot table
// Transaction structs, status codes and sequencer states.
// ----------------------------------------------------------------------------
package sltf_pkg;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_FULL     = 3'd2,
      ST_SHORT    = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   localparam logic CMD_CREDIT = 1'b0;
   localparam logic CMD_DEBIT  = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic signed [63:0] amount;
      logic [31:0]        lot_key;
      logic [63:0]        created_at;
      logic               permit_negative;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [63:0] balance_now;
      logic [4:0]         lots_held;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_SCAN_WAIT,
      S_SHIFT_UP,
      S_INSERT,
      S_KEY_EVAL,
      S_DRAIN_WAIT,
      S_DRAIN_EVAL,
      S_SHIFT_DOWN,
      S_FINISH,
      S_OUT
   } state_type;

endpackage

// ===== hw/rtl/sorted_lot_table_fifo_debit.sv =====
// Credit, keyed debit and oldest-first debit step through the lot table one
// entry at a time, bound by the single read port of the lot table.
// Throughput: one transaction at a time; req_stall is high while busy.
// Reset: synchronous; balance and lot count clear, table contents are undefined.
// ----------------------------------------------------------------------------
// sorted_lot_table_fifo_debit: sorted lot table with oldest-first debit
// Sequencer over a single-read-port lot table: search, shift, insert and drain.
// ----------------------------------------------------------------------------
module sorted_lot_table_fifo_debit
   import sltf_pkg::*;
#(
   parameter int LOT_SLOTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = (LOT_SLOTS > 1) ? $clog2(LOT_SLOTS) : 1;
   localparam int CW = $clog2(LOT_SLOTS + 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(LOT_SLOTS);

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic signed [63:0] bal_ff, bal_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic signed [63:0] left_ff, left_in;
   logic [2:0]         st_ff, st_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [31:0]        wr_id, rd_id;
   logic [63:0]        wr_time, rd_time;
   logic signed [63:0] wr_amt, rd_amt;

   // shared 64-bit adder
   logic signed [63:0] add_a, add_b, add_s;
   assign add_s = add_a + add_b;

   sltf_mem #(.AW(AW), .DEPTH(LOT_SLOTS)) u_mem (
      .clock, .wr_en, .wr_addr, .wr_id, .wr_time, .wr_amt,
      .rd_addr, .rd_id, .rd_time, .rd_amt
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bal_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bal_ff       <= bal_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      left_ff <= left_in;
      st_ff   <= st_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      bal_in       = bal_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_id        = rd_id;
      wr_time      = rd_time;
      wr_amt       = rd_amt;
      rd_addr      = idx_ff[AW-1:0];
      add_a        = bal_ff;
      add_b        = req_ff.amount;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            idx_in  = '0;
            left_in = req_ff.amount;
            st_in   = ST_OK;
            if (req_ff.cmd == CMD_CREDIT) begin
               // overflow of bal + amt with amt > 0
               if (req_ff.amount <= 0 || req_ff.lot_key == '0) begin
                  st_in = ST_INVALID; state_in = S_OUT;
               end else if (!bal_ff[63] && add_s[63]) begin
                  st_in = ST_OVERFLOW; state_in = S_OUT;
               end else if (cnt_ff >= SLOTS_C) begin
                  st_in = ST_FULL; state_in = S_OUT;
               end else begin
                  state_in = (cnt_ff == '0) ? S_INSERT : S_SCAN_WAIT;
               end
            end else begin
               add_b = -req_ff.amount;
               if (req_ff.amount <= 0) begin
                  st_in = ST_INVALID; state_in = S_OUT;
               end else if (bal_ff[63] && !add_s[63]) begin
                  st_in = ST_OVERFLOW; state_in = S_OUT;
               end else if (cnt_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = (req_ff.lot_key != '0) ? S_SCAN_WAIT : S_DRAIN_WAIT;
               end
            end
         end
         S_SCAN_WAIT: state_in = (req_ff.cmd == CMD_CREDIT) ? S_SCAN : S_KEY_EVAL;
         S_SCAN: begin
            // rd_* holds entry idx
            if (rd_time > req_ff.created_at ||
                (rd_time == req_ff.created_at && rd_id > req_ff.lot_key)) begin
               left_in  = {{(64-CW){1'b0}}, idx_ff};
               idx_in   = cnt_ff;
               state_in = S_SHIFT_UP;
            end else if (idx_ff + 1'b1 == cnt_ff) begin
               idx_in   = cnt_ff;
               state_in = S_INSERT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN_WAIT;
            end
         end
         S_SHIFT_UP: begin
            // left_ff holds insert position; read idx-1, write idx next pass
            rd_addr = AW'(idx_ff - 1'b1);
            if (idx_ff == left_ff[CW-1:0]) begin
               state_in = S_INSERT;
            end else begin
               state_in = S_SHIFT_DOWN;
            end
         end
         S_SHIFT_DOWN: begin
            // shared move step: write rd data to idx (credit) or idx-1 (debit), then continue
            wr_en = 1'b1;
            if (req_ff.cmd == CMD_CREDIT) begin
               idx_in   = idx_ff - 1'b1;
               state_in = S_SHIFT_UP;
            end else begin
               wr_addr = AW'(idx_ff - 1'b1);
               if (idx_ff + 1'b1 >= cnt_ff) begin
                  cnt_in   = cnt_ff - 1'b1;
                  idx_in   = '0;
                  state_in = (req_ff.lot_key != '0) ? S_FINISH : S_DRAIN_WAIT;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  rd_addr  = AW'(idx_ff + 1'b1);
                  state_in = S_SHIFT_DOWN;
               end
            end
         end
         S_INSERT: begin
            wr_en   = 1'b1;
            wr_id   = req_ff.lot_key;
            wr_time = req_ff.created_at;
            wr_amt  = req_ff.amount;
            cnt_in  = cnt_ff + 1'b1;
            bal_in  = add_s;
            state_in = S_OUT;
         end
         S_KEY_EVAL: begin
            if (rd_id == req_ff.lot_key) begin
               add_a = rd_amt;
               add_b = -req_ff.amount;
               if (rd_amt < req_ff.amount && !req_ff.permit_negative) begin
                  st_in = ST_SHORT; state_in = S_OUT;
               end else if (rd_amt <= req_ff.amount) begin
                  // remainder still owed once the lot is emptied
                  add_a   = req_ff.amount;
                  add_b   = -rd_amt;
                  left_in = add_s;
                  // remove lot: shift entries above down
                  if (idx_ff + 1'b1 >= cnt_ff) begin
                     cnt_in   = cnt_ff - 1'b1;
                     state_in = S_FINISH;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     rd_addr  = AW'(idx_ff + 1'b1);
                     state_in = S_SHIFT_DOWN;
                  end
               end else begin
                  wr_en    = 1'b1;
                  wr_amt   = add_s;
                  left_in  = '0;
                  state_in = S_FINISH;
               end
            end else if (idx_ff + 1'b1 == cnt_ff) begin
               state_in = S_FINISH;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN_WAIT;
            end
         end
         S_DRAIN_WAIT: begin
            rd_addr = '0;
            if (cnt_ff == '0 || left_ff <= 0) state_in = S_FINISH;
            else state_in = S_DRAIN_EVAL;
         end
         S_DRAIN_EVAL: begin
            // head lot in rd_*
            add_a = left_ff;
            add_b = -rd_amt;
            if (rd_amt <= 0) begin
               state_in = S_FINISH;
            end else if (rd_amt > left_ff) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               add_a    = rd_amt;
               add_b    = -left_ff;
               wr_amt   = add_s;
               left_in  = '0;
               state_in = S_FINISH;
            end else begin
               left_in = add_s;
               if (cnt_ff == CW'(1)) begin
                  cnt_in   = '0;
                  state_in = S_DRAIN_WAIT;
               end else begin
                  idx_in   = CW'(1);
                  rd_addr  = AW'(1);
                  state_in = S_SHIFT_DOWN;
               end
            end
         end
         S_FINISH: begin
            add_b = -req_ff.amount;
            state_in = S_OUT;
            if (req_ff.cmd == CMD_DEBIT && st_ff == ST_OK) begin
               bal_in = add_s;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = st_ff;
               rsp_in.balance_now   = bal_in;
               rsp_in.lots_held     = 5'(cnt_ff);
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // shortfall on finish
      if (state_ff == S_FINISH && req_ff.cmd == CMD_DEBIT && st_ff == ST_OK &&
          left_ff > 0 && !req_ff.permit_negative) begin
         st_in  = ST_SHORT;
         bal_in = bal_ff;
      end
   end

endmodule

// ===== hw/rtl/sltf_mem.sv =====
// ----------------------------------------------------------------------------
// sltf_mem: lot table storage
// One write port and one registered read port per field.
// ----------------------------------------------------------------------------
module sltf_mem
   import sltf_pkg::*;
#(
   parameter int AW = 4,
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [31:0]        wr_id,
   input  logic [63:0]        wr_time,
   input  logic signed [63:0] wr_amt,
   input  logic [AW-1:0]      rd_addr,
   output logic [31:0]        rd_id,
   output logic [63:0]        rd_time,
   output logic signed [63:0] rd_amt
);

   logic [31:0]        ids_mem   [DEPTH];
   logic [63:0]        times_mem [DEPTH];
   logic signed [63:0] amts_mem  [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ids_mem[wr_addr]   <= wr_id;
         times_mem[wr_addr] <= wr_time;
         amts_mem[wr_addr]  <= wr_amt;
      end
      rd_id   <= ids_mem[rd_addr];
      rd_time <= times_mem[rd_addr];
      rd_amt  <= amts_mem[rd_addr];
   end

endmodule

// ===== dv/sorted_lot_table_fifo_debit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_lot_table_fifo_debit_test: self-checking bench for the lot table
// Drives a directed table and random credit/debit traffic with random idle
// and stall bursts, predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module sorted_lot_table_fifo_debit_test
   import sltf_pkg::*;
;

   localparam int SLOTS      = 16;
   localparam int N_RANDOM   = 1900;
   localparam int IDLE_LIMIT = 20000;
   localparam longint BAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint BAL_MIN = 64'sh8000_0000_0000_0000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   sorted_lot_table_fifo_debit #(.LOT_SLOTS(SLOTS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   longint      ledger_balance;
   int          ledger_count;
   logic [31:0] ledger_ids[SLOTS];
   logic [63:0] ledger_times[SLOTS];
   longint      ledger_amounts[SLOTS];

   rsp_type pending_rsp[$];
   logic    pending_known[$];
   rsp_type typed_rsp[$];

   int  mismatch_count;
   int  idle_cycles;
   bit  quiet_mode;
   bit  long_hold;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   function automatic void drop_lot(input int pos);
      for (int k = pos; k + 1 < ledger_count; k++) begin
         ledger_ids[k]     = ledger_ids[k + 1];
         ledger_times[k]   = ledger_times[k + 1];
         ledger_amounts[k] = ledger_amounts[k + 1];
      end
      ledger_count--;
   endfunction

   function automatic status_type post_credit(input longint amt, input logic [31:0] key,
                                              input logic [63:0] when);
      int pos;
      if (amt <= 0 || key == 0) return ST_INVALID;
      if (ledger_balance > BAL_MAX - amt) return ST_OVERFLOW;
      if (ledger_count >= SLOTS) return ST_FULL;
      for (pos = 0; pos < ledger_count; pos++) begin
         if (ledger_times[pos] > when) break;
         if (ledger_times[pos] == when && ledger_ids[pos] > key) break;
      end
      for (int k = ledger_count; k > pos; k--) begin
         ledger_ids[k]     = ledger_ids[k - 1];
         ledger_times[k]   = ledger_times[k - 1];
         ledger_amounts[k] = ledger_amounts[k - 1];
      end
      ledger_ids[pos] = key;
      ledger_times[pos] = when;
      ledger_amounts[pos] = amt;
      ledger_count++;
      ledger_balance += amt;
      return ST_OK;
   endfunction

   function automatic status_type post_debit(input longint amt, input logic [31:0] key,
                                             input bit neg_ok);
      longint left;
      longint take;
      left = amt;
      if (amt <= 0) return ST_INVALID;
      if (ledger_balance < BAL_MIN + amt) return ST_OVERFLOW;
      if (key != 0) begin
         for (int k = 0; k < ledger_count; k++) begin
            if (ledger_ids[k] == key) begin
               take = left;
               if (ledger_amounts[k] < take) begin
                  if (!neg_ok) return ST_SHORT;
                  take = ledger_amounts[k];
               end
               ledger_amounts[k] -= take;
               if (ledger_amounts[k] == 0) drop_lot(k);
               left -= take;
               break;
            end
         end
      end else begin
         while (ledger_count > 0 && left > 0) begin
            take = ledger_amounts[0];
            if (take > left) take = left;
            if (take <= 0) break;
            ledger_amounts[0] -= take;
            if (ledger_amounts[0] == 0) drop_lot(0);
            left -= take;
         end
      end
      if (left > 0 && !neg_ok) return ST_SHORT;
      ledger_balance -= amt;
      return ST_OK;
   endfunction

   function automatic rsp_type predict_ledger(input req_type r);
      rsp_type o;
      status_type st;
      if (r.cmd == CMD_CREDIT) st = post_credit(r.amount, r.lot_key, r.created_at);
      else st = post_debit(r.amount, r.lot_key, r.permit_negative);
      o.status = st;
      o.balance_now = ledger_balance;
      o.lots_held = ledger_count[4:0];
      return o;
   endfunction

   // directed rows
   typedef struct {
      req_type req;
      bit      known;
      rsp_type rsp;
   } row_type;

   function automatic req_type mk(input logic c, input longint a, input logic [31:0] k,
                                  input logic [63:0] t, input logic n);
      req_type r;
      r.cmd = c; r.amount = a; r.lot_key = k; r.created_at = t; r.permit_negative = n;
      return r;
   endfunction

   function automatic rsp_type mr(input status_type s, input longint b, input int n);
      rsp_type o;
      o.status = s; o.balance_now = b; o.lots_held = n[4:0];
      return o;
   endfunction

   // sender; valid stays high into the next transaction unless a gap is drawn
   task automatic send_item(input req_type r, input bit known, input rsp_type want);
      int gap;
      rsp_type p;
      if (!quiet_mode && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      p = predict_ledger(r);
      pending_rsp.push_back(p);
      pending_known.push_back(known);
      typed_rsp.push_back(want);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_type random_item(input bit well_formed);
      req_type r;
      int sel;
      r.cmd = 1'($urandom_range(0, 1));
      r.permit_negative = ($urandom_range(0, 3) == 0);
      r.created_at = {$urandom, $urandom};
      if ($urandom_range(0, 1)) r.created_at = 64'($urandom_range(0, 7));
      r.lot_key = $urandom_range(1, 6);
      if ($urandom_range(0, 7) == 0) r.lot_key = {$urandom};
      if (r.cmd == CMD_DEBIT && $urandom_range(0, 2) == 0) r.lot_key = 0;
      sel = $urandom_range(0, 9);
      if (sel < 7) r.amount = 64'($urandom_range(1, 1000));
      else if (sel < 9) r.amount = {$urandom, $urandom} >> $urandom_range(1, 63);
      else r.amount = {$urandom, $urandom};
      if (well_formed && r.amount <= 0) r.amount = 1;
      if (!well_formed) begin
         r.amount = {$urandom, $urandom};
         if ($urandom_range(0, 1)) r.lot_key = 0;
      end
      if (r.amount == 0 && well_formed) r.amount = 5;
      return r;
   endfunction

   // receiver and checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", '0, '0);
         end else begin
            rsp_type w;
            rsp_type t;
            bit kn;
            w = pending_rsp.pop_front();
            kn = pending_known.pop_front();
            t = typed_rsp.pop_front();
            if (kn) w = t;
            if (rsp_data.status !== w.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(w.status));
            if (rsp_data.balance_now !== w.balance_now)
               report_mismatch("balance_now", rsp_data.balance_now, w.balance_now);
            if (rsp_data.lots_held !== w.lots_held)
               report_mismatch("lots_held", 64'(rsp_data.lots_held), 64'(w.lots_held));
         end
      end
   end

   initial begin
      int burst;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            long_hold = 1'b0;
         end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || long_hold)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      row_type rows[$];
      req_type r;
      rsp_type none;
      none = '0;
      mismatch_count = 0;
      quiet_mode = 1'b0;
      long_hold = 1'b0;
      ledger_balance = 0;
      ledger_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      rows.push_back('{mk(CMD_DEBIT, 10, 0, 0, 0), 1, mr(ST_SHORT, 0, 0)});
      rows.push_back('{mk(CMD_CREDIT, 0, 5, 0, 0), 1, mr(ST_INVALID, 0, 0)});
      rows.push_back('{mk(CMD_CREDIT, BAL_MIN, 5, 0, 0), 1, mr(ST_INVALID, 0, 0)});
      rows.push_back('{mk(CMD_CREDIT, 7, 0, 0, 0), 1, mr(ST_INVALID, 0, 0)});
      rows.push_back('{mk(CMD_DEBIT, -1, 0, 0, 1), 1, mr(ST_INVALID, 0, 0)});
      rows.push_back('{mk(CMD_DEBIT, 5, 9, 0, 1), 1, mr(ST_OK, -5, 0)});
      rows.push_back('{mk(CMD_DEBIT, BAL_MAX, 0, 0, 1), 1, mr(ST_OVERFLOW, -5, 0)});
      rows.push_back('{mk(CMD_CREDIT, BAL_MAX, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1),
                       1, mr(ST_OK, BAL_MAX - 5, 1)});
      rows.push_back('{mk(CMD_CREDIT, 10, 3, 0, 0), 1, mr(ST_OVERFLOW, BAL_MAX - 5, 1)});
      rows.push_back('{mk(CMD_DEBIT, BAL_MAX, 32'hFFFF_FFFF, 0, 0), 1,
                       mr(ST_OK, -5, 0)});
      rows.push_back('{mk(CMD_CREDIT, 20, 4, 5, 0), 0, none});
      rows.push_back('{mk(CMD_CREDIT, 30, 2, 5, 0), 0, none});
      rows.push_back('{mk(CMD_CREDIT, 40, 2, 5, 1), 0, none});
      rows.push_back('{mk(CMD_CREDIT, 50, 1, 1, 0), 0, none});
      rows.push_back('{mk(CMD_DEBIT, 60, 2, 0, 0), 0, none});
      rows.push_back('{mk(CMD_DEBIT, 15, 2, 0, 0), 0, none});
      rows.push_back('{mk(CMD_DEBIT, 70, 0, 0, 0), 0, none});
      rows.push_back('{mk(CMD_DEBIT, 500, 0, 0, 0), 0, none});
      rows.push_back('{mk(CMD_DEBIT, 500, 0, 0, 1), 0, none});
      for (int i = 0; i < SLOTS + 1; i++)
         rows.push_back('{mk(CMD_CREDIT, 1 + i, i + 1, 64'(SLOTS - i), 0), 0, none});
      foreach (rows[i]) send_item(rows[i].req, rows[i].known, rows[i].rsp);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 300) begin
            // fill the block behind a held-off receiver
            long_hold = 1'b1;
         end
         if (i == 600) begin
            req_valid <= 1'b0;
            @(negedge clock);
            while (pending_rsp.size() != 0) @(negedge clock);
         end
         if (i == N_RANDOM - 150) quiet_mode = 1'b1;
         r = random_item($urandom_range(0, 9) != 0);
         send_item(r, 0, none);
      end
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
